@@ design/coc_pkg.sv @@
// Shared types and constants for the cursor overlay compositor.
package coc_pkg;

  // Width of a signed frame-to-cursor offset (12-bit coordinate minus 13-bit position).
  localparam int DXW = 14;
  // Width of a byte address into the shape store before wrapping.
  localparam int BAW = 18;
  // Width of a word index into the shape store before wrapping.
  localparam int WIW = BAW - 2;

  typedef enum logic [1:0] {
    MODE_COLOR     = 2'd0,
    MODE_MONO      = 2'd1,
    MODE_MASKED    = 2'd2,
    MODE_COLOR_ALT = 2'd3
  } shape_mode_t;

  // Side information that travels with a pixel beat alongside the store read data.
  typedef struct packed {
    logic        hit;
    logic [1:0]  off0;
    logic [1:0]  off1;
    logic [2:0]  bit_idx;
    logic [31:0] frame;
  } coc_ctl_t;

endpackage

@@ design/coc_store.sv @@
// Cursor shape store: one write port and two registered read ports.
module coc_store
  import coc_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [31:0]   rdata0_r,
  output logic [31:0]   rdata1_r
);

  logic [31:0] mem [DEPTH];

  // Reads return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0_r <= mem[raddr0];
      rdata1_r <= mem[raddr1];
    end
  end

endmodule

@@ design/coc_mix.sv @@
// Compositing datapath: byte extraction, mode logic, blend products, divide-by-255 and the output register.
module coc_mix
  import coc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  shape_mode_t shape_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  coc_ctl_t    in_ctl,
  input  logic [31:0] rdata0,
  input  logic [31:0] rdata1,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel,
  output logic        out_cursor_hit
);

  logic              a_v_r, a_v_nxt;
  logic              a_hit_r;
  logic              a_blend_r;
  logic [31:0]       a_direct_r;
  logic [23:0]       a_c_r;
  logic [7:0]        a_fa_r;
  logic [2:0][15:0]  a_prod_r;
  logic              out_v_r, out_v_nxt;
  logic [31:0]       out_pixel_r;
  logic              out_hit_r;

  logic              o_ready_in;
  logic              a_ready;
  logic [63:0]       pair;
  logic [31:0]       c;
  logic [31:0]       f;
  logic [7:0]        byte_a;
  logic [7:0]        byte_x;
  logic              and_bit;
  logic              xor_bit;
  logic [7:0]        inv_a;
  logic [31:0]       direct;
  logic              use_blend;
  logic [2:0][15:0]  prod;
  logic [2:0][15:0]  qsum;
  logic [2:0][7:0]   chan;
  logic [31:0]       res;

  assign o_ready_in = !out_v_r || out_ready;
  assign a_ready    = !a_v_r || o_ready_in;
  assign in_ready   = a_ready;

  // The cursor pixel may straddle two store words; byte offsets select from the pair.
  assign pair    = {rdata1, rdata0};
  assign c       = 32'(pair >> {in_ctl.off0, 3'b000});
  assign f       = in_ctl.frame;
  assign byte_a  = 8'(rdata0 >> {in_ctl.off0, 3'b000});
  assign byte_x  = 8'(rdata1 >> {in_ctl.off1, 3'b000});
  assign and_bit = byte_a[~in_ctl.bit_idx];
  assign xor_bit = byte_x[~in_ctl.bit_idx];
  assign inv_a   = 8'hFF - c[31:24];

  always_comb begin
    direct    = f;
    use_blend = 1'b0;
    if (in_ctl.hit) begin
      unique case (shape_mode)
        MODE_MONO: begin
          direct = and_bit ? f : (f & 32'hFF00_0000);
          if (xor_bit) begin
            direct = direct ^ 32'h00FF_FFFF;
          end
        end
        MODE_MASKED: begin
          direct = (c[31:24] != 8'h00) ? ((f ^ c) | 32'hFF00_0000) : (c | 32'hFF00_0000);
        end
        default: begin
          if (c[31:24] == 8'h00) begin
            direct = f;
          end else if (c[31:24] == 8'hFF) begin
            direct = c;
          end else begin
            use_blend = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = {8'd0, f[8*k +: 8]} * {8'd0, inv_a};
    end
  end

  // Exact floor division by 255 for products below 65280.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qsum[k] = a_prod_r[k] + 16'd1 + {8'd0, a_prod_r[k][15:8]};
      chan[k] = qsum[k][15:8] + a_c_r[8*k +: 8];
    end
  end

  assign res = a_blend_r ? {a_fa_r, chan[2], chan[1], chan[0]} : a_direct_r;

  assign a_v_nxt   = a_ready ? in_valid : a_v_r;
  assign out_v_nxt = o_ready_in ? a_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r   <= a_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_hit_r    <= in_ctl.hit;
      a_blend_r  <= use_blend;
      a_direct_r <= direct;
      a_c_r      <= c[23:0];
      a_fa_r     <= f[31:24];
      a_prod_r   <= prod;
    end
    if (o_ready_in && a_v_r) begin
      out_pixel_r <= res;
      out_hit_r   <= a_hit_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pixel      = out_pixel_r;
  assign out_cursor_hit = out_hit_r;

  a_moves_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && o_ready_in) |=> out_v_r)
    else $error("blend stage beat did not reach the output register");

  miss_never_blends: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && !a_hit_r) |-> !a_blend_r)
    else $error("pixel outside the cursor selected the blend path");

  a_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && !o_ready_in) |=> (a_v_r && $stable(a_prod_r) && $stable(a_direct_r)))
    else $error("blend stage changed while the output was stalled");

endmodule

@@ design/cursor_overlay_compositor_unit.sv @@
// Top level of the cursor overlay compositor: config registers, input and address stages, store and compositing.
// A pixel beat moves through stages 0, 1 and 2, the blend stage and the output register to out_.
// Throughput: one beat per cycle unless out_ stalls; each pixel uses both store read ports once, each write one slot.
// An output stall holds each stage in place, and a stage refills as soon as its successor frees.
// Reset (rst_n, synchronous): clears all valids and config registers; store contents stay undefined.
module cursor_overlay_compositor_unit
  import coc_pkg::*;
#(
  parameter int STORE_WORDS = 4096,
  parameter int COORD_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [11:0] in_store_addr,
  input  logic [31:0] in_store_word,
  input  logic [11:0] in_pix_col,
  input  logic [11:0] in_pix_row,
  input  logic [31:0] in_frame_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel,
  output logic        out_cursor_hit,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int AW        = $clog2(STORE_WORDS);
  localparam int MOD_STEPS = WIW - AW + 1;
  localparam int CB        = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam logic [11:0] COORD_MASK = 12'((33'd1 << CB) - 33'd1);

  typedef enum logic [2:0] {
    REG_SHAPE_MODE   = 3'd0,
    REG_POS_X        = 3'd1,
    REG_POS_Y        = 3'd2,
    REG_SHAPE_WIDTH  = 3'd3,
    REG_SHAPE_HEIGHT = 3'd4,
    REG_SHAPE_PITCH  = 3'd5
  } cfg_reg_t;

  // Configuration registers. The user must change them only with no beat in flight;
  // the block does not enforce this. The input, address and mode logic read them directly.
  shape_mode_t mode_r;
  logic [12:0] pos_x_r;
  logic [12:0] pos_y_r;
  logic [6:0]  width_r;
  logic [7:0]  height_r;
  logic [9:0]  pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_COLOR;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      width_r  <= '0;
      height_r <= '0;
      pitch_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SHAPE_MODE:   mode_r   <= shape_mode_t'(cfg_data[1:0]);
        REG_POS_X:        pos_x_r  <= cfg_data;
        REG_POS_Y:        pos_y_r  <= cfg_data;
        REG_SHAPE_WIDTH:  width_r  <= cfg_data[6:0];
        REG_SHAPE_HEIGHT: height_r <= cfg_data[7:0];
        REG_SHAPE_PITCH:  pitch_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage. The cursor-relative offsets and the rectangle test are worked
  // out from the incoming beat, so stage 0 already holds small unsigned offsets.
  // ---------------------------------------------------------------------------
  logic [11:0]           col_m;
  logic [11:0]           row_m;
  logic signed [DXW-1:0] dx;
  logic signed [DXW-1:0] dy;
  logic [7:0]            draw_h;
  logic                  in_hit;

  assign col_m  = in_pix_col & COORD_MASK;
  assign row_m  = in_pix_row & COORD_MASK;
  assign dx     = $signed({2'b00, col_m}) - $signed({pos_x_r[12], pos_x_r});
  assign dy     = $signed({2'b00, row_m}) - $signed({pos_y_r[12], pos_y_r});
  // In monochrome mode the shape holds the AND plane above the XOR plane, so only
  // half of the rows are drawn.
  assign draw_h = (mode_r == MODE_MONO) ? {1'b0, height_r[7:1]} : height_r;
  assign in_hit = !dx[DXW-1] && (dx < $signed({7'd0, width_r}))
               && !dy[DXW-1] && (dy < $signed({6'd0, draw_h}));

  logic        s0_v_r, s0_v_nxt;
  logic        s0_pix_r;
  logic [11:0] s0_waddr_r;
  logic [31:0] s0_wdata_r;
  logic        s0_hit_r;
  logic [6:0]  s0_ux_r;
  logic [7:0]  s0_uy_r;
  logic [31:0] s0_frame_r;

  logic        s1_v_r, s1_v_nxt;
  logic [BAW-1:0] s1_b0_r;
  logic [BAW-1:0] s1_b1_r;
  logic        s1_hit_r;
  logic [2:0]  s1_ux3_r;
  logic [31:0] s1_frame_r;

  logic        s2_v_r, s2_v_nxt;
  coc_ctl_t    s2_ctl_r;

  logic        mix_ready;
  logic        s2_ready;
  logic        s1_ready;
  logic        s1_adv;
  logic        s0_adv;

  // Each stage takes a new beat when it is empty or its own beat moves on.
  assign s2_ready = !s2_v_r || mix_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign s1_adv   = s1_v_r && s2_ready;
  assign s0_adv   = s0_v_r && s1_ready;
  assign in_ready = !s0_v_r || s1_ready;

  assign s0_v_nxt = in_ready ? in_valid : s0_v_r;
  // A store write finishes when it leaves stage 0 and leaves no beat behind.
  assign s1_v_nxt = s1_ready ? (s0_v_r && s0_pix_r) : s1_v_r;
  assign s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_pix_r   <= in_kind;
      s0_waddr_r <= in_store_addr;
      s0_wdata_r <= in_store_word;
      s0_hit_r   <= in_hit;
      s0_ux_r    <= dx[6:0];
      s0_uy_r    <= dy[7:0];
      s0_frame_r <= in_frame_pixel;
    end
  end

  // ---------------------------------------------------------------------------
  // Address stage. Color modes read the four bytes at row*pitch + 4*col, which can
  // cross into the next word, so the second port fetches the following word.
  // Monochrome reads the AND byte on port 0 and the XOR byte draw_h rows further
  // down on port 1.
  // ---------------------------------------------------------------------------
  logic [7:0]     row_x;
  logic [BAW-1:0] row_base0;
  logic [BAW-1:0] row_base1;
  logic [BAW-1:0] col_bytes;
  logic [BAW-1:0] col_bits;
  logic [BAW-1:0] b0_nxt;
  logic [BAW-1:0] b1_nxt;
  logic           is_mono;

  assign is_mono   = (mode_r == MODE_MONO);
  assign row_x     = 8'(s0_uy_r + draw_h);
  assign row_base0 = {10'd0, s0_uy_r} * {8'd0, pitch_r};
  assign row_base1 = {10'd0, row_x} * {8'd0, pitch_r};
  assign col_bytes = {9'd0, s0_ux_r, 2'b00};
  assign col_bits  = {14'd0, s0_ux_r[6:3]};
  assign b0_nxt    = is_mono ? (row_base0 + col_bits) : (row_base0 + col_bytes);
  assign b1_nxt    = is_mono ? (row_base1 + col_bits) : (b0_nxt + BAW'(4));

  always_ff @(posedge clk) begin
    if (s1_ready && s0_v_r && s0_pix_r) begin
      s1_b0_r    <= b0_nxt;
      s1_b1_r    <= b1_nxt;
      s1_hit_r   <= s0_hit_r;
      s1_ux3_r   <= s0_ux_r[2:0];
      s1_frame_r <= s0_frame_r;
    end
  end

  // Word indices wrap modulo the store depth; a short chain of conditional
  // subtractions handles depths that are not a power of two.
  function automatic logic [AW-1:0] wrap_word(input logic [WIW-1:0] w);
    logic [WIW:0] v;
    v = {1'b0, w};
    for (int j = MOD_STEPS - 1; j >= 0; j--) begin
      if (v >= ((WIW+1)'(STORE_WORDS) << j)) begin
        v = v - ((WIW+1)'(STORE_WORDS) << j);
      end
    end
    return v[AW-1:0];
  endfunction

  logic [AW-1:0] raddr0;
  logic [AW-1:0] raddr1;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   rdata0;
  logic [31:0]   rdata1;

  assign raddr0    = wrap_word(s1_b0_r[BAW-1:2]);
  assign raddr1    = wrap_word(s1_b1_r[BAW-1:2]);
  // Writes beyond the store are dropped.
  assign mem_we    = s0_adv && !s0_pix_r && ({20'd0, s0_waddr_r} < 32'(STORE_WORDS));
  assign mem_waddr = AW'(s0_waddr_r);

  // Writes happen as they leave stage 0 and reads as pixels leave stage 1, both in
  // beat order; a read at the same edge as a younger write still sees the old word.
  coc_store #(
    .DEPTH (STORE_WORDS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .we       (mem_we),
    .waddr    (mem_waddr),
    .wdata    (s0_wdata_r),
    .re       (s1_adv),
    .raddr0   (raddr0),
    .raddr1   (raddr1),
    .rdata0_r (rdata0),
    .rdata1_r (rdata1)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_ctl_r.hit     <= s1_hit_r;
      s2_ctl_r.off0    <= s1_b0_r[1:0];
      s2_ctl_r.off1    <= s1_b1_r[1:0];
      s2_ctl_r.bit_idx <= s1_ux3_r;
      s2_ctl_r.frame   <= s1_frame_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Compositing: mode logic and blend products, then the divide-by-255 and the
  // output register that parts this block from the downstream consumer.
  // ---------------------------------------------------------------------------
  coc_mix u_mix (
    .clk            (clk),
    .rst_n          (rst_n),
    .shape_mode     (mode_r),
    .in_valid       (s2_v_r),
    .in_ready       (mix_ready),
    .in_ctl         (s2_ctl_r),
    .rdata0         (rdata0),
    .rdata1         (rdata1),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel      (out_pixel),
    .out_cursor_hit (out_cursor_hit)
  );

  stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s0_v_r)
    else $error("input stalled while stage 0 is empty");

  read_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !mix_ready) |=> ($stable(rdata0) && $stable(rdata1)))
    else $error("store read data changed under a stalled beat");

  write_leaves_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_adv && !s0_pix_r) |=> !s1_v_r)
    else $error("store write beat produced a pixel beat");

endmodule

@@ test/cursor_overlay_compositor_unit_tb.sv @@
// Self-checking testbench for the cursor overlay compositor: shape store, all four modes, stalls.
`timescale 1ns / 100ps

module cursor_overlay_compositor_unit_tb;
  import coc_pkg::*;

  localparam int STORE_WORDS = 4096;
  localparam int COORD_MAX = 4095;
  // Pipeline latency of the block, used to size the settling waits.
  localparam int PIPE_LATENCY = 4;
  // Length of the one long output hold-off, in cycles.
  localparam int LONG_HOLD = 300;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int WATCHDOG_CYCLES = 5000;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_PIXEL = 1'b1
  } beat_kind_t;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_POS_X      = 3'd1,
    REG_POS_Y      = 3'd2,
    REG_WIDTH      = 3'd3,
    REG_HEIGHT     = 3'd4,
    REG_PITCH      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        hit;
  } overlay_result_t;

  // Shadow of the compositor: its own copy of the shape store and the registers, the
  // composited pixels still owed by the block, and the mismatch count.
  class overlay_checker;
    bit [31:0]       shape_words [STORE_WORDS];
    bit              written [STORE_WORDS];
    shape_mode_t     mode;
    int              pos_x, pos_y, width, height, pitch;
    overlay_result_t pending_pixels[$];
    int unsigned     fails;
    int unsigned     results_seen;

    function void set_config(shape_mode_t m, int px, int py, int w, int h, int p);
      mode = m;
      pos_x = px;
      pos_y = py;
      width = w;
      height = h;
      pitch = p;
    endfunction

    // In monochrome mode the height covers both planes, so only half of it is drawn.
    function int draw_rows();
      return (mode == MODE_MONO) ? height / 2 : height;
    endfunction

    function bit covers(int col, int row);
      int dx, dy;
      dx = col - pos_x;
      dy = row - pos_y;
      return dx >= 0 && dx < width && dy >= 0 && dy < draw_rows();
    endfunction

    // Byte addresses wrap around the store, just as the word index does.
    function bit [7:0] byte_at(int unsigned addr);
      return 8'(shape_words[(addr >> 2) % STORE_WORDS] >> (8 * (addr & 3)));
    endfunction

    // Store words that this pixel's result depends on; empty when it misses the cursor.
    function void words_read(int col, int row, output int unsigned words[$]);
      int unsigned dx, dy, base, other;
      words = {};
      if (!covers(col, row)) return;
      dx = col - pos_x;
      dy = row - pos_y;
      if (mode == MODE_MONO) begin
        base = dy * pitch + dx / 8;
        other = base + draw_rows() * pitch;
        words = {(base >> 2) % STORE_WORDS, (other >> 2) % STORE_WORDS};
      end else begin
        base = dy * pitch + 4 * dx;
        words = {(base >> 2) % STORE_WORDS, ((base + 3) >> 2) % STORE_WORDS};
      end
    endfunction

    // Premultiplied blend: each color channel is scaled by (255 - alpha) / 255, rounded
    // down, and the cursor channel is added with 8-bit wrap. Frame alpha survives unless alpha is 255.
    function bit [31:0] blend(bit [31:0] f, bit [31:0] c);
      int unsigned a, fc, cc;
      bit [31:0] r;
      a = c[31:24];
      if (a == 0) return f;
      if (a == 255) return c;
      r = {f[31:24], 24'h0};
      for (int k = 0; k < 3; k++) begin
        fc = f[8*k +: 8];
        cc = c[8*k +: 8];
        r[8*k +: 8] = 8'((fc * (255 - a)) / 255 + cc);
      end
      return r;
    endfunction

    function overlay_result_t composite(int col, int row, bit [31:0] frame);
      overlay_result_t r;
      int unsigned dx, dy, base;
      bit [31:0] cur;
      bit [7:0] mask;
      r.pixel = frame;
      r.hit = covers(col, row);
      if (!r.hit) return r;
      dx = col - pos_x;
      dy = row - pos_y;
      if (mode == MODE_MONO) begin
        // Planes are stored most significant bit first; the XOR plane sits below the AND one.
        mask = 8'h80 >> (dx % 8);
        base = dy * pitch + dx / 8;
        if ((byte_at(base) & mask) == 0) r.pixel &= 32'hFF00_0000;
        if ((byte_at(base + draw_rows() * pitch) & mask) != 0) r.pixel ^= 32'h00FF_FFFF;
      end else begin
        base = dy * pitch + 4 * dx;
        cur = {byte_at(base + 3), byte_at(base + 2), byte_at(base + 1), byte_at(base)};
        if (mode == MODE_MASKED)
          r.pixel = ((cur[31:24] != 0) ? (frame ^ cur) : cur) | 32'hFF00_0000;
        else
          r.pixel = blend(frame, cur);
      end
      return r;
    endfunction

    function void note_beat(beat_kind_t kind, int unsigned addr, bit [31:0] word,
                            int col, int row, bit [31:0] frame);
      if (kind == KIND_WRITE) begin
        shape_words[addr] = word;
        written[addr] = 1'b1;
      end else begin
        pending_pixels.push_back(composite(col, row, frame));
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fails++;
    endtask

    task check_pixel(logic [31:0] pixel, logic hit);
      overlay_result_t want;
      results_seen++;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d with none pending: pixel %h hit %b",
                                  results_seen, pixel, hit));
        return;
      end
      want = pending_pixels.pop_front();
      if (hit !== want.hit)
        report_mismatch($sformatf("result %0d cursor_hit %b, expected %b",
                                  results_seen, hit, want.hit));
      if (pixel !== want.pixel)
        report_mismatch($sformatf("result %0d out_pixel %h, expected %h",
                                  results_seen, pixel, want.pixel));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [11:0] in_store_addr;
  logic [31:0] in_store_word;
  logic [11:0] in_pix_col;
  logic [11:0] in_pix_row;
  logic [31:0] in_frame_pixel;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_pixel;
  logic        out_cursor_hit;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  overlay_checker overlay;

  // Idling switches, redrawn now and then so that bursts alternate with gappy stretches.
  bit send_idling;
  bit recv_idling;
  // Raised by the stimulus to make the receiver hold off with out_ready low; the receiver clears it afterwards.
  bit hold_output_req;
  int unsigned quiet_cycles;

  cursor_overlay_compositor_unit #(
    .STORE_WORDS(STORE_WORDS),
    .COORD_BITS (12)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_store_addr (in_store_addr),
    .in_store_word (in_store_word),
    .in_pix_col    (in_pix_col),
    .in_pix_row    (in_pix_row),
    .in_frame_pixel(in_frame_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel     (out_pixel),
    .out_cursor_hit(out_cursor_hit),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Outputs are sampled at the rising edge, where every handshake takes place. The same
  // block keeps the watchdog: it counts edges at which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && out_ready) overlay.check_pixel(out_pixel, out_cursor_hit);
    if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("[cursor_overlay_compositor_unit] ERROR");
        $finish;
      end
    end
  end

  // Receiver: when idling, before each result it waits a random number of cycles with
  // out_ready low, and on request it holds off for one long stretch so the pipeline backs up.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_output_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_output_req = 1'b0;
      end
      stall = recv_idling ? $urandom_range(0, 14) : 0;
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat was taken. When no
  // gap is drawn, in_valid simply stays high into the next beat.
  task automatic send_beat(beat_kind_t kind, int unsigned addr, logic [31:0] word,
                           int col, int row, logic [31:0] frame);
    int unsigned gap;
    gap = send_idling ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind = kind;
    in_store_addr = 12'(addr);
    in_store_word = word;
    in_pix_col = 12'(col);
    in_pix_row = 12'(row);
    in_frame_pixel = frame;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    overlay.note_beat(kind, addr, word, col, row, frame);
    @(negedge clk);
  endtask

  // Fields that a beat's kind does not use are filled with noise.
  task automatic send_write(int unsigned addr, logic [31:0] word);
    send_beat(KIND_WRITE, addr, word, $urandom_range(0, COORD_MAX),
              $urandom_range(0, COORD_MAX), $urandom);
  endtask

  task automatic send_pixel(int col, int row, logic [31:0] frame);
    send_beat(KIND_PIXEL, $urandom_range(0, STORE_WORDS - 1), $urandom, col, row, frame);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (overlay.pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [12:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
  endtask

  // Registers change only with the block empty. Store writes leave no result behind, so
  // the task waits out more than the pipeline latency for the last of them to land.
  task automatic apply_config(shape_mode_t mode, int px, int py, int w, int h, int p);
    wait_for_results();
    repeat (PIPE_LATENCY + 2) @(negedge clk);
    write_reg(REG_SHAPE_MODE, 13'(mode));
    write_reg(REG_POS_X, 13'(px));
    write_reg(REG_POS_Y, 13'(py));
    write_reg(REG_WIDTH, 13'(w));
    write_reg(REG_HEIGHT, 13'(h));
    write_reg(REG_PITCH, 13'(p));
    cfg_we = 1'b0;
    overlay.set_config(mode, px, py, w, h, p);
  endtask

  // Shape words lean toward the alpha values that take the blend's shortcuts.
  function automatic logic [31:0] make_shape_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: w[31:24] = 8'h00;
      1: w[31:24] = 8'hFF;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] make_frame();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic under the current registers. Most pixels are aimed into the cursor
  // or just around its border; any store word that a pixel's result depends on is written
  // first, so no unwritten word is ever used. The rest are stray writes and pixels anywhere.
  task automatic run_random(int unsigned beats, bit long_hold, bit drain_midway);
    int unsigned sent, roll;
    int unsigned words[$];
    int col, row;
    bit mid_done;
    sent = 0;
    mid_done = 1'b0;
    while (sent < beats) begin
      if (sent % 40 == 0) begin
        send_idling = $urandom_range(0, 2) != 0;
        recv_idling = $urandom_range(0, 2) != 0;
      end
      // Several beats can go out per pass, so the midpoint is caught once it is passed.
      if (!mid_done && sent >= beats / 2) begin
        mid_done = 1'b1;
        if (long_hold) hold_output_req = 1'b1;
        if (drain_midway) wait_for_results();
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_write($urandom_range(0, STORE_WORDS - 1), make_shape_word());
        sent++;
      end else begin
        col = $urandom_range(0, COORD_MAX);
        row = $urandom_range(0, COORD_MAX);
        if (overlay.width > 0 && overlay.draw_rows() > 0 && roll < 90) begin
          if (roll < 75) begin
            col = overlay.pos_x + int'($urandom_range(0, overlay.width - 1));
            row = overlay.pos_y + int'($urandom_range(0, overlay.draw_rows() - 1));
          end else begin
            col = overlay.pos_x + int'($urandom_range(0, overlay.width + 3)) - 2;
            row = overlay.pos_y + int'($urandom_range(0, overlay.draw_rows() + 3)) - 2;
          end
          if (col < 0 || col > COORD_MAX) col = $urandom_range(0, COORD_MAX);
          if (row < 0 || row > COORD_MAX) row = $urandom_range(0, COORD_MAX);
        end
        overlay.words_read(col, row, words);
        foreach (words[i]) begin
          if (!overlay.written[words[i]] || $urandom_range(0, 3) == 0) begin
            send_write(words[i], make_shape_word());
            sent++;
          end
        end
        send_pixel(col, row, make_frame());
        sent++;
      end
    end
  endtask

  initial begin
    shape_mode_t mode;
    int w;
    overlay = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_WRITE;
    in_store_addr = '0;
    in_store_word = '0;
    in_pix_col = '0;
    in_pix_row = '0;
    in_frame_pixel = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SHAPE_MODE;
    cfg_data = '0;
    send_idling = 1'b0;
    recv_idling = 1'b0;
    hold_output_req = 1'b0;
    quiet_cycles = 0;
    overlay.set_config(MODE_COLOR, 0, 0, 0, 0, 0);
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Registers straight out of reset describe an empty cursor: everything passes through.
    send_pixel(0, 0, 32'hFFFF_FFFF);
    send_pixel(COORD_MAX, COORD_MAX, 32'h0000_0000);

    // A three-pixel color cursor with alpha 0, 255 and a partial value, plus a miss
    // just to its right.
    apply_config(MODE_COLOR, 0, 0, 3, 1, 12);
    send_write(0, 32'h0012_3456);
    send_write(1, 32'hFFAB_CDEF);
    send_write(2, 32'h8010_2030);
    send_pixel(0, 0, 32'hFFFF_FFFF);
    send_pixel(1, 0, 32'h7F80_C0FF);
    send_pixel(2, 0, 32'hFFFF_FFFF);
    send_pixel(3, 0, 32'h1234_5678);

    // Masked color: zero cursor alpha replaces, nonzero alpha XORs.
    apply_config(MODE_MASKED, 0, 0, 3, 1, 12);
    send_pixel(0, 0, 32'h00FF_00FF);
    send_pixel(2, 0, 32'h5A5A_A5A5);

    // Mode three composites like color mode.
    apply_config(MODE_COLOR_ALT, 0, 0, 3, 1, 12);
    send_pixel(2, 0, 32'hC0C0_C0C0);

    // Monochrome, one drawn row: the AND plane is word 0, the XOR plane word 1. The four
    // columns hit both ends of both bytes; the last pixel sits below the drawn half.
    apply_config(MODE_MONO, 0, 0, 16, 2, 4);
    send_pixel(0, 0, 32'h8899_AABB);
    send_pixel(7, 0, 32'h8899_AABB);
    send_pixel(8, 0, 32'hFFFF_FFFF);
    send_pixel(15, 0, 32'h0000_0000);
    send_pixel(0, 1, 32'h1357_9BDF);

    // Extreme register settings. The largest pitch and height make shape reads wrap
    // around the store; the corner cursor only covers the last frame pixel.
    apply_config(MODE_COLOR, 0, 0, 64, 128, 1023);
    run_random(60, 1'b0, 1'b0);
    apply_config(MODE_MONO, 0, 0, 64, 128, 1023);
    run_random(60, 1'b0, 1'b0);
    apply_config(MODE_COLOR_ALT, COORD_MAX, COORD_MAX, 1, 1, 0);
    run_random(60, 1'b0, 1'b0);
    apply_config(MODE_MASKED, -4096, -4096, 0, 0, 0);
    run_random(40, 1'b0, 1'b0);
    apply_config(MODE_MASKED, -10, -3, 64, 128, 256);
    run_random(60, 1'b0, 1'b0);

    // Random settings; one phase backs the pipeline up behind a long output hold-off and
    // another drains it completely in the middle.
    for (int i = 0; i < 6; i++) begin
      mode = shape_mode_t'($urandom_range(0, 3));
      w = $urandom_range(0, 64);
      apply_config(mode, int'($urandom_range(0, 4100)) - 100, int'($urandom_range(0, 4100)) - 100,
                   w, $urandom_range(0, 128),
                   $urandom_range(0, 1) ? int'($urandom_range(0, 1023))
                                        : ((mode == MODE_MONO) ? (w + 7) / 8 : 4 * w));
      run_random(90, i == 1, i == 3);
    end

    wait_for_results();
    repeat (PIPE_LATENCY * 3) @(negedge clk);
    if (overlay.fails == 0) begin
      $display("[cursor_overlay_compositor_unit] OK");
    end else begin
      $display("[cursor_overlay_compositor_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/coc_pkg.sv
design/coc_store.sv
design/coc_mix.sv
design/cursor_overlay_compositor_unit.sv
test/cursor_overlay_compositor_unit_tb.sv
